### sv/cis_pkg.sv
// cis_pkg: shared types, register indexes and result packing for the
// index search block. No dependencies.
`default_nettype none

package cis_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTargetKey      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetChecksum = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTableFileSize  = 2'd2;

  // Input opcodes
  localparam logic OpEntry     = 1'b0;
  localparam logic OpStreamEnd = 1'b1;

  typedef struct packed {
    logic             op;
    logic [DataW-1:0] key;
    logic [DataW-1:0] checksum;
    logic [DataW-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [DataW-1:0] position;
    logic [DataW-1:0] size;
  } result_t;

  typedef struct packed {
    logic [DataW-1:0] target_key;
    logic [DataW-1:0] target_checksum;
    logic [DataW-1:0] table_file_size;
  } cfg_t;

  // Zero position or zero size reports not found with zeroed fields.
  function automatic result_t make_result(logic [DataW-1:0] position,
                                          logic [DataW-1:0] size);
    result_t r;
    logic    ok;
    ok         = (position != '0) && (size != '0);
    r.found    = ok;
    r.position = ok ? position : '0;
    r.size     = ok ? size : '0;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/cis_walk.sv
// cis_walk: walk state (held entry, key-only fallback) and the per-entry
// compare / size logic. Depends on cis_pkg.
`default_nettype none

module cis_walk (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire cis_pkg::entry_t entry_i,
  input  wire cis_pkg::cfg_t   cfg_i,
  output logic                 res_valid_o,
  output cis_pkg::result_t     res_o
);
  import cis_pkg::*;

  logic             have_prev_q, have_prev_d;
  logic [DataW-1:0] prev_key_q, prev_key_d;
  logic [DataW-1:0] prev_chk_q, prev_chk_d;
  logic [DataW-1:0] prev_off_q, prev_off_d;
  logic             fb_valid_q, fb_valid_d;
  logic [DataW-1:0] fb_pos_q, fb_pos_d;
  logic [DataW-1:0] fb_size_q, fb_size_d;

  logic [DataW-1:0] end_pos;
  logic [DataW-1:0] size;
  logic             key_hit;
  logic             full_hit;
  logic             fb_use;

  assign end_pos  = (entry_i.offset != '0) ? entry_i.offset : cfg_i.table_file_size;
  assign size     = end_pos - prev_off_q;
  assign key_hit  = (prev_key_q == cfg_i.target_key) && (prev_off_q != '0);
  assign full_hit = key_hit && (prev_chk_q == cfg_i.target_checksum);

  always_comb begin
    have_prev_d = have_prev_q;
    prev_key_d  = prev_key_q;
    prev_chk_d  = prev_chk_q;
    prev_off_d  = prev_off_q;
    fb_valid_d  = fb_valid_q;
    fb_pos_d    = fb_pos_q;
    fb_size_d   = fb_size_q;
    res_valid_o = 1'b0;
    res_o       = make_result('0, '0);
    fb_use      = 1'b0;

    if (entry_i.op == OpStreamEnd) begin
      // End of stream: held entry has no successor, report fallback only
      fb_use      = fb_valid_q && (cfg_i.target_key != '0);
      res_valid_o = 1'b1;
      res_o       = fb_use ? make_result(fb_pos_q, fb_size_q) : make_result('0, '0);
      have_prev_d = 1'b0;
      fb_valid_d  = 1'b0;
    end else if (!have_prev_q) begin
      // First entry of a walk: hold it only
      have_prev_d = 1'b1;
      prev_key_d  = entry_i.key;
      prev_chk_d  = entry_i.checksum;
      prev_off_d  = entry_i.offset;
    end else if (full_hit) begin
      res_valid_o = 1'b1;
      res_o       = make_result(prev_off_q, size);
      have_prev_d = 1'b0;
      fb_valid_d  = 1'b0;
    end else begin
      // Keep the first key-only hit of the walk
      if (key_hit && !fb_valid_q) begin
        fb_valid_d = 1'b1;
        fb_pos_d   = prev_off_q;
        fb_size_d  = size;
      end
      if (entry_i.offset == '0) begin
        fb_use      = fb_valid_d && (cfg_i.target_key != '0);
        res_valid_o = 1'b1;
        res_o       = fb_use ? make_result(fb_pos_d, fb_size_d) : make_result('0, '0);
        have_prev_d = 1'b0;
        fb_valid_d  = 1'b0;
      end else begin
        prev_key_d = entry_i.key;
        prev_chk_d = entry_i.checksum;
        prev_off_d = entry_i.offset;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      fb_valid_q  <= 1'b0;
    end else if (step_i) begin
      have_prev_q <= have_prev_d;
      fb_valid_q  <= fb_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      prev_key_q <= prev_key_d;
      prev_chk_q <= prev_chk_d;
      prev_off_q <= prev_off_d;
      fb_pos_q   <= fb_pos_d;
      fb_size_q  <= fb_size_d;
    end
  end

endmodule

`default_nettype wire

### sv/cis_result_reg.sv
// cis_result_reg: output register holding one result until transferred.
// Depends on cis_pkg.
`default_nettype none

module cis_result_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire cis_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cis_pkg::result_t      res_o
);
  import cis_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Slot frees up when empty or drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

### sv/cheat_index_search_top.sv
// cheat_index_search_top: input register, configuration registers, walk
// logic and result register. Depends on cis_pkg, cis_walk, cis_result_reg.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | op_i, entry_key_i, entry_checksum_i,
//           |                         | entry_offset_i
//   out     | out_valid_o/out_ready_i | found_o, match_position_o, match_size_o
//   cfg     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// One entry per cycle sustained unless the result register stalls. An entry
// is checked against the held entry while in the input register; its result
// (if any) goes to the output result register as the entry steps on. Reset
// clears the walk, the configuration registers and both valid flags. A stalled
// result register holds the walk stage; an empty input register still takes an entry.
`default_nettype none

module cheat_index_search_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // entry stream
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic [cis_pkg::DataW-1:0]    entry_key_i,
  input  wire logic [cis_pkg::DataW-1:0]    entry_checksum_i,
  input  wire logic [cis_pkg::DataW-1:0]    entry_offset_i,
  // results
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              found_o,
  output logic [cis_pkg::DataW-1:0]         match_position_o,
  output logic [cis_pkg::DataW-1:0]         match_size_o,
  // configuration writes
  input  wire logic                         cfg_we_i,
  input  wire logic [cis_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cis_pkg::DataW-1:0]    cfg_data_i
);
  import cis_pkg::*;

  cfg_t    cfg_q;
  logic    in_valid_q;
  entry_t  in_q;
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Registers written at any index; unused indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTargetKey:      cfg_q.target_key      <= cfg_data_i;
        CfgTargetChecksum: cfg_q.target_checksum <= cfg_data_i;
        CfgTableFileSize:  cfg_q.table_file_size <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held entry into the walk whenever the result slot can take it
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q.op       <= op_i;
      in_q.key      <= entry_key_i;
      in_q.checksum <= entry_checksum_i;
      in_q.offset   <= entry_offset_i;
    end
  end

  cis_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .entry_i     (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cis_result_reg u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign found_o          = out_res.found;
  assign match_position_o = out_res.position;
  assign match_size_o     = out_res.size;

endmodule

`default_nettype wire
